/* src/bpa_pkg.sv */
package bpa_pkg;

    localparam int PAGE_W  = 20;
    localparam int SIZE_W  = 11;
    localparam int COUNT_W = 7;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_KV_BASE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UV_BASE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KP_BASE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_BASE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_K_POOL  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_U_POOL  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_U_VIRT  = 3'd6;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_RUN   = 2'd1;
    localparam logic [1:0] ST_EXHAUST  = 2'd2;
    localparam logic [1:0] ST_BAD_CNT  = 2'd3;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;       // capture request
        logic clr_step;   // clear-pass step
        logic vscan;      // examine virtual bit of last read
        logic vmark;      // mark virtual bit at mark index
        logic pmark;      // mark physical bit found
        logic rd;         // issue memory read at scan index
        logic emit;       // load output register
        logic [1:0] emit_status;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic bad_cnt;
        logic scan_end;   // index of registered read reached effective size
        logic run_found;
        logic bit_free;   // registered read data is zero
        logic mark_done;  // last run bit is being marked
        logic last_page;  // current page is the final one
    } t_sts;

endpackage

/* src/bpa_ctrl.sv */
module bpa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  logic           i_out_busy,
    output bpa_pkg::t_cmd  o_cmd,
    input  bpa_pkg::t_sts  i_sts
);
    import bpa_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CHECK, S_VRD, S_VCHK, S_VMARK,
        S_PRD, S_PCHK, S_EMIT, S_EWAIT
    } t_state;

    t_state r_state, n_state;
    t_cmd   n_cmd;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                n_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd.load = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.bad_cnt) begin
                    n_cmd.emit = 1'b1;
                    n_cmd.emit_status = ST_BAD_CNT;
                    n_state = S_EWAIT;
                end else begin
                    n_cmd.rd = 1'b1;
                    n_state = S_VRD;
                end
            end
            S_VRD: begin
                if (i_sts.scan_end) begin
                    n_cmd.emit = 1'b1;
                    n_cmd.emit_status = ST_NO_RUN;
                    n_state = S_EWAIT;
                end else begin
                    n_state = S_VCHK;
                end
            end
            S_VCHK: begin
                n_cmd.vscan = 1'b1;
                if (i_sts.run_found) begin
                    n_state = S_VMARK;
                end else begin
                    n_cmd.rd = 1'b1;
                    n_state = S_VRD;
                end
            end
            S_VMARK: begin
                n_cmd.vmark = 1'b1;
                if (i_sts.mark_done) begin
                    n_cmd.rd = 1'b1;
                    n_state = S_PRD;
                end
            end
            S_PRD: begin
                if (i_sts.scan_end) begin
                    n_cmd.emit = 1'b1;
                    n_cmd.emit_status = ST_EXHAUST;
                    n_state = S_EWAIT;
                end else begin
                    n_state = S_PCHK;
                end
            end
            S_PCHK: begin
                if (i_sts.bit_free) begin
                    n_cmd.pmark = 1'b1;
                    n_cmd.emit = 1'b1;
                    n_cmd.emit_status = ST_OK;
                    n_state = S_EMIT;
                end else begin
                    n_cmd.rd = 1'b1;
                    n_state = S_PRD;
                end
            end
            S_EMIT: begin
                if (!i_out_busy) begin
                    if (i_sts.last_page) begin
                        n_state = S_IDLE;
                    end else begin
                        n_cmd.rd = 1'b1;
                        n_state = S_PRD;
                    end
                end
            end
            S_EWAIT: begin
                if (!i_out_busy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd = n_cmd;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_in_stall)
        else $error("input taken while busy");
    a_clear_first: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_state == S_CLEAR))
        else $error("reset did not start clear pass");
    a_emit_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && i_out_busy) |=> (r_state == S_EMIT))
        else $error("left emit while output occupied");
endmodule

/* src/bpa_datapath.sv */
module bpa_datapath #(
    parameter int POOL_PAGES = 1024,
    parameter int MAX_RUN    = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bpa_pkg::t_cmd                 i_cmd,
    output bpa_pkg::t_sts                 o_sts,
    input  logic                          i_cfg_we,
    input  logic [bpa_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bpa_pkg::PAGE_W-1:0]    i_cfg_data,
    input  logic                          i_pool_select,
    input  logic [bpa_pkg::COUNT_W-1:0]   i_page_count,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic [bpa_pkg::PAGE_W-1:0]    o_virt_page,
    output logic [bpa_pkg::PAGE_W-1:0]    o_phys_page,
    output logic [1:0]                    o_status,
    output logic                          o_last
);
    import bpa_pkg::*;

    localparam int AW = $clog2(POOL_PAGES);
    localparam int SW = AW + 1;
    localparam int MW = 2 ** SW;

    logic [PAGE_W-1:0] r_kv_base, r_uv_base, r_kp_base, r_up_base;
    logic [SIZE_W-1:0] r_k_pool, r_u_pool, r_u_virt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kv_base <= PAGE_W'(786688);
            r_uv_base <= PAGE_W'(32840);
            r_kp_base <= PAGE_W'(512);
            r_up_base <= PAGE_W'(1024);
            r_k_pool  <= SIZE_W'(512);
            r_u_pool  <= SIZE_W'(512);
            r_u_virt  <= SIZE_W'(1024);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KV_BASE: r_kv_base <= i_cfg_data;
                CFG_UV_BASE: r_uv_base <= i_cfg_data;
                CFG_KP_BASE: r_kp_base <= i_cfg_data;
                CFG_UP_BASE: r_up_base <= i_cfg_data;
                CFG_K_POOL:  r_k_pool  <= i_cfg_data[SIZE_W-1:0];
                CFG_U_POOL:  r_u_pool  <= i_cfg_data[SIZE_W-1:0];
                CFG_U_VIRT:  r_u_virt  <= i_cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp a size register to POOL_PAGES.
    function automatic logic [SW-1:0] clamp(input logic [SIZE_W-1:0] n);
        logic [31:0] w;
        w = 32'(n);
        if (w > 32'(POOL_PAGES)) return SW'(POOL_PAGES);
        return SW'(w);
    endfunction

    // Virtual and physical bitmaps; the pool bit selects the upper half.
    logic r_vmem [MW];
    logic r_pmem [MW];

    logic              r_user;
    logic [COUNT_W-1:0] r_cnt;
    logic [SW-1:0]     r_vsize, r_psize;
    logic [PAGE_W-1:0] r_vbase, r_pbase;
    logic [SW-1:0]     r_idx;      // scan index
    logic [SW-1:0]     r_ridx;     // index of registered read
    logic [COUNT_W-1:0] r_run;
    logic [SW-1:0]     r_start;
    logic [COUNT_W-1:0] r_k;       // marks done / pages emitted
    logic              r_vrd, r_prd;
    logic [SW-1:0]     r_clr;

    wire [AW:0] w_vaddr = {r_user, r_idx[AW-1:0]};
    wire [AW:0] w_paddr = {r_user, r_idx[AW-1:0]};
    wire [SW-1:0] w_mark_idx = r_start + SW'(r_k);
    wire [AW:0] w_maddr = {r_user, w_mark_idx[AW-1:0]};
    wire [AW:0] w_pmark = {r_user, r_ridx[AW-1:0]};
    wire [AW:0] w_caddr = r_clr[AW:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            r_vmem[w_caddr] <= 1'b0;
        end else if (i_cmd.vmark) begin
            r_vmem[w_maddr] <= 1'b1;
        end
        if (i_cmd.rd) r_vrd <= r_vmem[w_vaddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            r_pmem[w_caddr] <= 1'b0;
        end else if (i_cmd.pmark) begin
            r_pmem[w_pmark] <= 1'b1;
        end
        if (i_cmd.rd) r_prd <= r_pmem[w_paddr];
    end

    logic r_pphase;
    wire w_rbit = r_pphase ? r_prd : r_vrd;
    wire [COUNT_W-1:0] w_run_next = r_run + COUNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_step && r_clr != SW'(MW - 1)) begin
            r_clr <= r_clr + SW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_user  <= i_pool_select;
            r_cnt   <= i_page_count;
            r_vsize <= clamp(i_pool_select ? r_u_virt : r_k_pool);
            r_psize <= clamp(i_pool_select ? r_u_pool : r_k_pool);
            r_vbase <= i_pool_select ? r_uv_base : r_kv_base;
            r_pbase <= i_pool_select ? r_up_base : r_kp_base;
            r_idx   <= '0;
            r_run   <= '0;
            r_k     <= '0;
            r_pphase <= 1'b0;
        end
        if (i_cmd.rd) begin
            r_ridx <= r_idx;
            r_idx  <= r_idx + SW'(1);
        end
        if (i_cmd.vscan) begin
            if (w_rbit) r_run <= '0;
            else begin
                r_run <= w_run_next;
                if (w_run_next == r_cnt) begin
                    r_start <= r_ridx + SW'(1) - SW'(r_cnt);
                    r_idx   <= '0;
                end
            end
        end
        if (i_cmd.vmark) begin
            if (r_k + COUNT_W'(1) == r_cnt) begin
                r_k <= '0;
                r_pphase <= 1'b1;
            end else begin
                r_k <= r_k + COUNT_W'(1);
            end
        end
        if (i_cmd.pmark) r_k <= r_k + COUNT_W'(1);
    end

    // Scan reaches the end when the bit just read lies at or beyond the size.
    wire [SW-1:0] w_lim = r_pphase ? r_psize : r_vsize;
    assign o_sts.clr_done  = (r_clr == SW'(MW - 1));
    assign o_sts.bad_cnt   = (r_cnt == '0) || (r_cnt > COUNT_W'(MAX_RUN));
    assign o_sts.scan_end  = (r_ridx >= w_lim);
    assign o_sts.run_found = !w_rbit && (w_run_next == r_cnt);
    assign o_sts.bit_free  = !w_rbit;
    assign o_sts.mark_done = (r_k + COUNT_W'(1) == r_cnt);
    assign o_sts.last_page = (r_k == r_cnt);

    // Output register.
    wire [PAGE_W-1:0] w_vpage = r_vbase + PAGE_W'(r_start) + PAGE_W'(r_k);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
        if (i_cmd.emit) begin
            o_status <= i_cmd.emit_status;
            if (i_cmd.emit_status == ST_OK) begin
                o_virt_page <= w_vpage;
                o_phys_page <= r_pbase + PAGE_W'(r_ridx);
                o_last      <= (r_k + COUNT_W'(1) == r_cnt);
            end else if (i_cmd.emit_status == ST_EXHAUST) begin
                o_virt_page <= w_vpage;
                o_phys_page <= '0;
                o_last      <= 1'b1;
            end else begin
                o_virt_page <= '0;
                o_phys_page <= '0;
                o_last      <= 1'b1;
            end
        end
    end

    a_mark_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.vmark |-> (w_mark_idx < r_vsize))
        else $error("virtual mark beyond pool");
    a_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.vscan |-> (r_run < r_cnt))
        else $error("run count overran request");
    a_pmark_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pmark |-> !r_prd)
        else $error("marked a used physical page");
endmodule

/* src/bitmap_page_allocator.sv */
// Channel | Direction | Handshake              | Payload
// in      | input     | i_in_valid/o_in_stall  | pool_select, page_count
// out     | output    | o_out_valid/i_out_stall| virt_page, phys_page, status, last
// cfg     | input     | i_cfg_we               | i_cfg_idx, i_cfg_data
// After reset a clearing pass runs over every bitmap entry of both pools (each pool
// rounded up to a power of two); no request is taken then.
// A request scans the virtual bitmap bit by bit, up to the selected virtual size.
// The run is then marked bit by bit; each physical page is found by scanning the
// physical bitmap bit by bit and is then handed over as a result.
// One request is in flight at a time; a stalled result holds the physical scan.
module bitmap_page_allocator #(
    parameter int POOL_PAGES = 1024,
    parameter int MAX_RUN    = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bpa_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bpa_pkg::PAGE_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_pool_select,
    input  logic [bpa_pkg::COUNT_W-1:0]   i_page_count,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [bpa_pkg::PAGE_W-1:0]    o_virt_page,
    output logic [bpa_pkg::PAGE_W-1:0]    o_phys_page,
    output logic [1:0]                    o_status,
    output logic                          o_last
);
    import bpa_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    bpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_out_busy (o_out_valid && i_out_stall),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    bpa_datapath #(.POOL_PAGES(POOL_PAGES), .MAX_RUN(MAX_RUN)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_pool_select (i_pool_select),
        .i_page_count  (i_page_count),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_virt_page   (o_virt_page),
        .o_phys_page   (o_phys_page),
        .o_status      (o_status),
        .o_last        (o_last)
    );
endmodule
